// ===== sv/ttib_pkg.sv =====
`default_nettype none
package ttib_pkg;

  localparam int CHAR_W       = 8;
  localparam int ALPHA_CHARS  = 16;
  localparam int ALPHA_W      = CHAR_W * ALPHA_CHARS;
  localparam int BASE_LEN_W   = 5;
  localparam int DIGIT_IDX_W  = 4;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_LENGTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_DIGIT,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic                   hit;
    logic [DIGIT_IDX_W-1:0] index;
    logic [BASE_LEN_W-1:0]  used_len;
    logic                   base_ok;
  } alpha_res_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage
`default_nettype wire

// ===== sv/ttib_alpha.sv =====
`default_nettype none
module ttib_alpha #(
  parameter int MAX_BASE = 16
) (
  input  wire logic [ttib_pkg::BASE_LEN_W-1:0] base_length,
  input  wire logic [ttib_pkg::ALPHA_W-1:0]    alphabet,
  input  wire logic [ttib_pkg::CHAR_W-1:0]     char_code,
  output ttib_pkg::alpha_res_t                 res
);

  localparam logic [ttib_pkg::BASE_LEN_W-1:0] MAX_LEN = ttib_pkg::BASE_LEN_W'(MAX_BASE);

  logic [ttib_pkg::CHAR_W-1:0]      chars [ttib_pkg::ALPHA_CHARS];
  logic [ttib_pkg::BASE_LEN_W-1:0]  used_len;
  logic                             bad;
  logic                             hit;
  logic [ttib_pkg::DIGIT_IDX_W-1:0] hit_index;
  logic                             ok;

  always_comb begin
    for (int k = 0; k < ttib_pkg::ALPHA_CHARS; k++) begin
      chars[k] = alphabet[k*ttib_pkg::CHAR_W +: ttib_pkg::CHAR_W];
    end
  end

  assign used_len = (base_length > MAX_LEN) ? MAX_LEN : base_length;

  // digit lookup: lowest matching index wins
  always_comb begin
    hit       = 1'b0;
    hit_index = '0;
    for (int i = MAX_BASE - 1; i >= 0; i--) begin
      if ((ttib_pkg::BASE_LEN_W'(i) < used_len) && (chars[i] == char_code)) begin
        hit       = 1'b1;
        hit_index = ttib_pkg::DIGIT_IDX_W'(i);
      end
    end
  end

  // alphabet check: no sign, blank or NUL, no duplicates
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < MAX_BASE; i++) begin
      if (ttib_pkg::BASE_LEN_W'(i) < base_length) begin
        if ((chars[i] == ttib_pkg::CHAR_NUL) || (chars[i] == ttib_pkg::CHAR_PLUS) ||
            (chars[i] == ttib_pkg::CHAR_MINUS) || ttib_pkg::is_space(chars[i])) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if ((ttib_pkg::BASE_LEN_W'(j) < base_length) && (chars[j] == chars[i])) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign ok  = (base_length >= ttib_pkg::BASE_LEN_W'(2)) &&
               (base_length <= MAX_LEN) && !bad;
  assign res = {hit, hit_index, used_len, ok};

endmodule
`default_nettype wire

// ===== sv/text_to_integer_custom_base_top.sv =====
`default_nettype none
// Streaming text-to-integer converter with a programmable digit alphabet. One character
// beat is accepted per cycle; leading blanks are skipped, a run of signs sets the sign,
// and digits accumulate as value*base+index until the first non-digit. The beat marked
// last yields one result, registered and presented the cycle after it is accepted; a
// waiting result holds off all further input until it is taken, so in_ready drops only
// while a result stalls. The per-character work is one alphabet compare plus one
// multiply-add by the base, done combinationally before the accumulator register. Write
// base_length and the alphabet words only while no text is in flight.
module text_to_integer_custom_base_top #(
  parameter int MAX_BASE    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [ttib_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ttib_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [ttib_pkg::CHAR_W-1:0]        in_char_code,
  input  wire logic                               in_last,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [VALUE_WIDTH-1:0]           out_value,
  output logic                                    out_base_ok
);

  localparam int HALF_W = ttib_pkg::ALPHA_W / 2;

  logic [ttib_pkg::BASE_LEN_W-1:0] base_length_r;
  logic [HALF_W-1:0]               alpha_low_r;
  logic [HALF_W-1:0]               alpha_high_r;

  ttib_pkg::phase_t phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;

  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_value_r;
  logic                   out_base_ok_r;

  ttib_pkg::alpha_res_t alpha;
  logic in_fire, blank, at_sign;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_length_r <= '0;
      alpha_low_r   <= '0;
      alpha_high_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ttib_pkg::CFG_BASE_LENGTH:   base_length_r <= cfg_data[ttib_pkg::BASE_LEN_W-1:0];
        ttib_pkg::CFG_ALPHABET_LOW:  alpha_low_r   <= cfg_data;
        ttib_pkg::CFG_ALPHABET_HIGH: alpha_high_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  ttib_alpha #(
    .MAX_BASE (MAX_BASE)
  ) u_alpha (
    .base_length (base_length_r),
    .alphabet    ({alpha_high_r, alpha_low_r}),
    .char_code   (in_char_code),
    .res         (alpha)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign blank    = ttib_pkg::is_space(in_char_code);
  assign at_sign  = (phase_r == ttib_pkg::PH_SIGN) || ((phase_r == ttib_pkg::PH_SPACE) && !blank);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      ttib_pkg::PH_SPACE,
      ttib_pkg::PH_SIGN,
      ttib_pkg::PH_DIGIT: begin
        priority if ((phase_r == ttib_pkg::PH_SPACE) && blank) begin
          phase_nxt = ttib_pkg::PH_SPACE;
        end else if (at_sign && ((in_char_code == ttib_pkg::CHAR_MINUS) ||
                                 (in_char_code == ttib_pkg::CHAR_PLUS))) begin
          phase_nxt = ttib_pkg::PH_SIGN;
        end else if (alpha.hit) begin
          phase_nxt = ttib_pkg::PH_DIGIT;
        end else begin
          phase_nxt = ttib_pkg::PH_DONE;
        end
      end
      ttib_pkg::PH_DONE: phase_nxt = ttib_pkg::PH_DONE;
      default:           phase_nxt = ttib_pkg::PH_SPACE;
    endcase
  end

  always_comb begin
    neg_nxt = neg_r ^ (at_sign && (in_char_code == ttib_pkg::CHAR_MINUS));
    acc_nxt = acc_r;
    if (phase_nxt == ttib_pkg::PH_DIGIT) begin
      acc_nxt = VALUE_WIDTH'(acc_r * VALUE_WIDTH'(alpha.used_len)) + VALUE_WIDTH'(alpha.index);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ttib_pkg::PH_SPACE;
      neg_r   <= 1'b0;
      acc_r   <= '0;
    end else if (in_fire) begin
      if (in_last) begin
        phase_r <= ttib_pkg::PH_SPACE;
        neg_r   <= 1'b0;
        acc_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && in_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (in_fire && in_last) begin
      out_base_ok_r <= alpha.base_ok;
      if (!alpha.base_ok) begin
        out_value_r <= '0;
      end else if (neg_nxt) begin
        out_value_r <= '0 - acc_nxt;
      end else begin
        out_value_r <= acc_nxt;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_value   = $signed(out_value_r);
  assign out_base_ok = out_base_ok_r;

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last) |=> out_valid_r)
    else $error("last beat did not produce a result");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_base_ok_r) |-> (out_value_r == '0))
    else $error("invalid alphabet result not zero");

  a_last_clears_parse: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last) |=> ((phase_r == ttib_pkg::PH_SPACE) && !neg_r && (acc_r == '0)))
    else $error("parse state not cleared after last beat");

  a_done_holds_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_last && (phase_r == ttib_pkg::PH_DONE)) |=> $stable(acc_r))
    else $error("accumulator moved after parse ended");

endmodule
`default_nettype wire

// ===== tb/sv/text_to_integer_custom_base_checker.sv =====
`timescale 1ns / 100ps
module text_to_integer_custom_base_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [ttib_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ttib_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [ttib_pkg::CHAR_W-1:0]        in_char_code,
  input  logic                               in_last,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [31:0]                 out_value,
  input  logic                               out_base_ok,
  output int                                 mismatches,
  output int                                 waiting
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               base_ok;
  } parsed_t;

  parsed_t          parsed_q[$];
  parsed_t          want;
  parsed_t          got;
  int               fails = 0;

  ttib_pkg::phase_t phase;
  logic             neg;
  logic [31:0]      acc;
  logic [4:0]       cfg_len;
  logic [127:0]     alphabet;

  function automatic logic [7:0] alpha_byte(input int i);
    return alphabet[8*i +: 8];
  endfunction

  function automatic logic blank(input logic [7:0] c);
    return (c == ttib_pkg::CHAR_SPACE) ||
           ((c >= ttib_pkg::CHAR_TAB) && (c <= ttib_pkg::CHAR_CR));
  endfunction

  function automatic int radix();
    return (cfg_len > ttib_pkg::ALPHA_CHARS) ? ttib_pkg::ALPHA_CHARS : int'(cfg_len);
  endfunction

  function automatic logic alphabet_ok();
    int i;
    int j;
    logic [7:0] c;
    if (cfg_len < 2 || cfg_len > ttib_pkg::ALPHA_CHARS) return 1'b0;
    for (i = 0; i < cfg_len; i++) begin
      c = alpha_byte(i);
      if (c == ttib_pkg::CHAR_NUL || c == ttib_pkg::CHAR_PLUS ||
          c == ttib_pkg::CHAR_MINUS || blank(c)) return 1'b0;
      for (j = i + 1; j < cfg_len; j++)
        if (alpha_byte(j) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int digit_of(input logic [7:0] c);
    int i;
    for (i = 0; i < radix(); i++)
      if (alpha_byte(i) == c) return i;
    return -1;
  endfunction

  // same fall-through as the parser: blank -> sign -> digit -> done
  task automatic absorb_char(input logic [7:0] c);
    int d;
    if (phase == ttib_pkg::PH_SPACE) begin
      if (blank(c)) return;
      phase = ttib_pkg::PH_SIGN;
    end
    if (phase == ttib_pkg::PH_SIGN) begin
      if (c == ttib_pkg::CHAR_MINUS) begin
        neg = ~neg;
        return;
      end
      if (c == ttib_pkg::CHAR_PLUS) return;
      phase = ttib_pkg::PH_DIGIT;
    end
    if (phase == ttib_pkg::PH_DIGIT) begin
      d = digit_of(c);
      if (d < 0) phase = ttib_pkg::PH_DONE;
      else acc = acc * 32'(radix()) + 32'(d);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase = ttib_pkg::PH_SPACE;
      neg = 1'b0;
      acc = '0;
      cfg_len = '0;
      alphabet = '0;
      parsed_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          ttib_pkg::CFG_BASE_LENGTH:   cfg_len = cfg_data[4:0];
          ttib_pkg::CFG_ALPHABET_LOW:  alphabet[63:0] = cfg_data;
          ttib_pkg::CFG_ALPHABET_HIGH: alphabet[127:64] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        absorb_char(in_char_code);
        if (in_last) begin
          want.base_ok = alphabet_ok();
          want.value = !want.base_ok ? 32'sd0 : neg ? -$signed(acc) : $signed(acc);
          parsed_q.push_back(want);
          phase = ttib_pkg::PH_SPACE;
          neg = 1'b0;
          acc = '0;
        end
      end
      if (out_valid && out_ready) begin
        got.value = out_value;
        got.base_ok = out_base_ok;
        if (parsed_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected result beat: value %0d base_ok %0b", got.value, got.base_ok);
          fails++;
        end else begin
          want = parsed_q.pop_front();
          if (got.value !== want.value || got.base_ok !== want.base_ok) begin
            if (fails < 10)
              $display("mismatch: expected value %0d base_ok %0b, got value %0d base_ok %0b",
                       want.value, want.base_ok, got.value, got.base_ok);
            fails++;
          end
        end
      end
    end
    waiting <= parsed_q.size();
    mismatches <= fails;
  end

endmodule

// ===== tb/sv/text_to_integer_custom_base_top_test.sv =====
`timescale 1ns / 100ps
module text_to_integer_custom_base_top_test;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [ttib_pkg::CFG_INDEX_W-1:0] cfg_index = ttib_pkg::CFG_BASE_LENGTH;
  logic [ttib_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [ttib_pkg::CHAR_W-1:0]      in_char_code = '0;
  logic                             in_last = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [31:0]               out_value;
  logic                             out_base_ok;

  int                     mismatches;
  int                     waiting;
  int                     send_idle = 0;
  int                     recv_idle = 0;
  int                     chars_sent = 0;
  int                     cur_len = 0;
  logic [127:0]           cur_alpha = '0;
  logic [7:0]             text_q[$];

  text_to_integer_custom_base_top dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_char_code, .in_last,
    .out_valid, .out_ready, .out_value, .out_base_ok
  );

  text_to_integer_custom_base_checker chk (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_char_code, .in_last,
    .out_valid, .out_ready, .out_value, .out_base_ok,
    .mismatches, .waiting
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  function automatic logic legal_digit(input logic [7:0] c);
    return !(c == ttib_pkg::CHAR_NUL || c == ttib_pkg::CHAR_PLUS ||
             c == ttib_pkg::CHAR_MINUS || c == ttib_pkg::CHAR_SPACE ||
             (c >= ttib_pkg::CHAR_TAB && c <= ttib_pkg::CHAR_CR));
  endfunction

  task automatic push_char(input logic [7:0] c, input logic l);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++)
      push_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // three back-to-back writes, enable dropped once after the last
  task automatic configure(input int len, input logic [63:0] lo, input logic [63:0] hi);
    cfg_wr_en <= 1'b1;
    cfg_index <= ttib_pkg::CFG_BASE_LENGTH;
    cfg_data <= 64'(len);
    @(posedge clk);
    cfg_index <= ttib_pkg::CFG_ALPHABET_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= ttib_pkg::CFG_ALPHABET_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_len = len;
    cur_alpha = {hi, lo};
  endtask

  task automatic pick_alphabet();
    int kind;
    int len;
    int n;
    int i;
    int j;
    int r;
    logic [7:0] c;
    bit used[256];
    logic [127:0] a;
    kind = $urandom_range(0, 9);
    len = $urandom_range(2, 16);
    if (kind == 1) len = 16;
    if (kind == 2) len = 2;
    if (kind == 8) len = $urandom_range(0, 1) ? $urandom_range(17, 31) : $urandom_range(0, 1);
    if (kind == 9) len = $urandom_range(0, 31);
    for (i = 0; i < 16; i++) a[8*i +: 8] = 8'($urandom_range(0, 255));
    n = (len > 16) ? 16 : len;
    for (i = 0; i < n; i++) begin
      do c = 8'($urandom_range(1, 255)); while (!legal_digit(c) || used[c]);
      used[c] = 1'b1;
      a[8*i +: 8] = c;
    end
    if (kind == 6) begin
      i = $urandom_range(0, len - 2);
      j = $urandom_range(i + 1, len - 1);
      a[8*j +: 8] = a[8*i +: 8];
    end
    if (kind == 7) begin
      i = $urandom_range(0, len - 1);
      r = $urandom_range(0, 8);
      case (r)
        0: c = ttib_pkg::CHAR_NUL;
        1: c = ttib_pkg::CHAR_PLUS;
        2: c = ttib_pkg::CHAR_MINUS;
        3: c = ttib_pkg::CHAR_SPACE;
        default: c = 8'(ttib_pkg::CHAR_TAB + r - 4);
      endcase
      a[8*i +: 8] = c;
    end
    if (kind == 9) a = $urandom_range(0, 1) ? '0 : '1;
    configure(len, a[63:0], a[127:64]);
  endtask

  task automatic make_text();
    int n;
    int u;
    int k;
    int r;
    text_q.delete();
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        r = $urandom_range(0, 5);
        text_q.push_back((r == 5) ? ttib_pkg::CHAR_SPACE : 8'(ttib_pkg::CHAR_TAB + r));
      end
      repeat ($urandom_range(0, 3))
        text_q.push_back($urandom_range(0, 1) ? ttib_pkg::CHAR_MINUS : ttib_pkg::CHAR_PLUS);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      u = (cur_len > 16) ? 16 : cur_len;
      repeat (n) begin
        k = (u == 0) ? 0 : $urandom_range(0, u - 1);
        text_q.push_back((u == 0) ? 8'($urandom_range(0, 255)) : cur_alpha[8*k +: 8]);
      end
      repeat ($urandom_range(0, 3)) text_q.push_back(8'($urandom_range(0, 255)));
    end
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic set_idle();
    if (chars_sent < 310) begin
      send_idle = 29;
      recv_idle = 61;
    end else if (chars_sent < 620) begin
      send_idle = 61;
      recv_idle = 29;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // decimal alphabet
    configure(10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938);
    set_idle();
    text_q = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, ttib_pkg::CHAR_SPACE, ttib_pkg::CHAR_MINUS,
               ttib_pkg::CHAR_PLUS, ttib_pkg::CHAR_MINUS, "4", "2", ttib_pkg::CHAR_NUL, 8'hFF};
    send_text();
    text_q = '{"7"};
    send_text();
    text_q = '{ttib_pkg::CHAR_MINUS};
    send_text();
    text_q = '{ttib_pkg::CHAR_NUL};
    send_text();
    text_q = '{"9", "9", "a"};
    send_text();
    drain();
    configure(1, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938);
    text_q = '{"5"};
    send_text();

    while (chars_sent < 920) begin
      drain();
      pick_alphabet();
      repeat ($urandom_range(1, 6)) begin
        set_idle();
        make_text();
        send_text();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
